// ===== sv/float32_sqrt_interpolated_macros.svh =====
// Assertion macros shared by the float32_sqrt_interpolated RTL.
`ifndef FLOAT32_SQRT_INTERPOLATED_MACROS_SVH
`define FLOAT32_SQRT_INTERPOLATED_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked out of reset.
`define FSI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define FSI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define FSI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define FSI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== sv/fsi_pkg.sv =====
// Package: widths, constants, interpolation types and the root/slope ROM tables.
`default_nettype none

package fsi_pkg;

    localparam int MANT_W  = 23;
    localparam int EXP_W   = 8;
    localparam int IDX_W   = 9;
    localparam int SLOPE_W = 14;
    localparam int OFS_W   = 15;
    localparam int PROD_W  = OFS_W + SLOPE_W;
    localparam int ROM_DEPTH = 1 << IDX_W;

    localparam logic [MANT_W-1:0]  TOP_BASE_ODD   = 23'd3474675;
    localparam logic [MANT_W-1:0]  TOP_BASE_EVEN  = 23'd8388607;
    localparam logic [SLOPE_W-1:0] TOP_SLOPE_ODD  = 14'd5792;
    localparam logic [SLOPE_W-1:0] TOP_SLOPE_EVEN = 14'd8192;
    localparam logic [SLOPE_W-1:0] MID_SLOPE      = 14'd8192;
    localparam logic [EXP_W-1:0]   EXP_BIAS_ODD   = 8'd64;
    localparam logic [EXP_W-1:0]   EXP_BIAS_EVEN  = 8'd63;
    localparam logic [OFS_W:0]     OFS_FULL       = 16'h8000;
    localparam logic [IDX_W-1:0]   MID_IDX        = 9'd256;

    typedef logic [ROM_DEPTH-1:0][MANT_W-1:0]  root_rom_t;
    typedef logic [ROM_DEPTH-1:0][SLOPE_W-1:0] slope_rom_t;

    // Table entry selected for one item.
    typedef struct packed {
        logic [MANT_W-1:0]  base;
        logic [SLOPE_W-1:0] slope;
        logic [OFS_W-1:0]   offset;
        logic               subtract;
    } interp_t;

    // Largest r with r*r <= n; n below 2^50.
    function automatic logic [63:0] fsi_isqrt(input logic [63:0] n);
        logic [63:0] r;
        logic [63:0] c;
        r = '0;
        for (int b = 25; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (c * c <= n)
                r = c;
        end
        return r;
    endfunction

    // Mantissa of the float32 nearest to the root for entry k.
    function automatic logic [MANT_W-1:0] root_entry(input logic [IDX_W-1:0] k);
        logic [63:0] n;
        logic [63:0] s;
        logic [63:0] d;
        if (k >= MID_IDX)
            n = 64'(k) << 38;
        else
            n = (64'd256 + 64'(k)) << 39;
        s = fsi_isqrt(n);
        if (n - s * s > s)
            s = s + 64'd1;
        d = s - (64'd1 << MANT_W);
        return d[MANT_W-1:0];
    endfunction

    // Top slope bits for entry k: round(sqrt(2^e / j)) shifted down.
    function automatic logic [SLOPE_W-1:0] slope_entry(input logic [IDX_W-1:0] k);
        logic [63:0] j;
        logic [63:0] lim;
        logic [63:0] m;
        logic [63:0] c;
        logic [63:0] t;
        logic [63:0] q;
        int          e;
        int          sh;
        if (k > MID_IDX) begin
            e  = 56;
            j  = 64'(k);
            sh = 11;
        end else begin
            e  = 55;
            j  = 64'd256 + 64'(k);
            sh = 10;
        end
        lim = 64'd1 << e;
        m   = '0;
        for (int b = 25; b >= 0; b--) begin
            c = m | (64'd1 << b);
            if (c * c * j <= lim)
                m = c;
        end
        t = 64'd2 * m + 64'd1;
        if (t * t * j < (64'd1 << (e + 2)))
            m = m + 64'd1;
        q = m >> sh;
        if (k == MID_IDX)
            return MID_SLOPE;
        return q[SLOPE_W-1:0];
    endfunction

    function automatic root_rom_t build_root_rom();
        root_rom_t r;
        for (int k = 0; k < ROM_DEPTH; k++)
            r[k] = root_entry(IDX_W'(k));
        return r;
    endfunction

    function automatic slope_rom_t build_slope_rom();
        slope_rom_t r;
        for (int k = 0; k < ROM_DEPTH; k++)
            r[k] = slope_entry(IDX_W'(k));
        return r;
    endfunction

    localparam root_rom_t  ROOT_ROM  = build_root_rom();
    localparam slope_rom_t SLOPE_ROM = build_slope_rom();

endpackage

`default_nettype wire

// ===== sv/fsi_table.sv =====
// Table stage: registered ROM read of base and slope, plus offset, for one item.
`default_nettype none

module fsi_table
    import fsi_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            load,   // item accepted this edge
    input  wire logic [MANT_W:0] frac,   // exponent LSB and mantissa
    output interp_t              sel
);

    logic [IDX_W-1:0]   idx;
    logic [IDX_W-1:0]   nidx;
    logic [IDX_W-1:0]   addr;
    logic [OFS_W-1:0]   low;
    logic [OFS_W:0]     back;
    logic               top_ones;
    logic [OFS_W-1:0]   offset_next;

    logic [MANT_W-1:0]  base_reg;
    logic [SLOPE_W-1:0] slope_reg;
    logic               top_ones_reg;
    logic               odd_reg;
    logic               subtract_reg;
    logic [OFS_W-1:0]   offset_reg;

    assign idx      = frac[MANT_W:OFS_W];
    assign nidx     = idx + IDX_W'(1);
    assign low      = frac[OFS_W-1:0];
    assign back     = OFS_FULL - {1'b0, low};
    assign top_ones = &frac[MANT_W-1:OFS_W-1];

    // backward reads the next entry; the all-ones case is always backward
    assign addr        = frac[OFS_W-1] ? nidx : idx;
    assign offset_next = frac[OFS_W-1] ? back[OFS_W-1:0] : low;

    always_ff @(posedge clk)
    begin
        if (load) begin
            base_reg     <= ROOT_ROM[addr];
            slope_reg    <= SLOPE_ROM[addr];
            top_ones_reg <= top_ones;
            odd_reg      <= frac[MANT_W];
            subtract_reg <= frac[OFS_W-1];
            offset_reg   <= offset_next;
        end
    end

    always_comb
    begin
        sel.offset   = offset_reg;
        sel.subtract = subtract_reg;
        if (top_ones_reg) begin
            sel.base  = odd_reg ? TOP_BASE_ODD : TOP_BASE_EVEN;
            sel.slope = odd_reg ? TOP_SLOPE_ODD : TOP_SLOPE_EVEN;
        end else begin
            sel.base  = base_reg;
            sel.slope = slope_reg;
        end
    end

endmodule

`default_nettype wire

// ===== sv/fsi_calc.sv =====
// Arithmetic stage: slope multiply, mantissa correction and exponent halving.
`default_nettype none

module fsi_calc
    import fsi_pkg::*;
(
    input  wire logic [EXP_W-1:0]        expo,
    input  wire interp_t                 sel,
    output logic [EXP_W+MANT_W-1:0]      root_next
);

    logic [PROD_W-1:0] prod;
    logic [OFS_W-1:0]  step;
    logic [MANT_W-1:0] sum;
    logic [EXP_W-1:0]  half_exp;

    assign prod = PROD_W'(sel.offset) * PROD_W'(sel.slope);
    assign step = prod[PROD_W-1:SLOPE_W];

    // carry or borrow out of the mantissa is dropped
    assign sum = sel.subtract ? sel.base - MANT_W'(step) : sel.base + MANT_W'(step);

    assign half_exp = (expo >> 1) + (expo[0] ? EXP_BIAS_ODD : EXP_BIAS_EVEN);

    assign root_next = (expo == '0) ? '0 : {half_exp, sum};

endmodule

`default_nettype wire

// ===== sv/float32_sqrt_interpolated.sv =====
// Top level: approximate float32 square root, two register stages.
//
//  channel | signals                     | width | direction
//  --------+-----------------------------+-------+----------
//  input   | in_valid, in_stall, operand | 32    | into block
//  output  | out_valid, out_stall, root  | 31    | out of block
//
// One item per cycle sustained while out_stall stays low; an accepted item
// passes the stage-one registers and then the result register before out_valid.
// The ROM read is registered at acceptance (with the exponent); the 15x14
// multiply and the 23-bit add sit between that register and the result one.
// Reset (rst_n low, async) empties both stages; no table clearing is needed.
// A stalled output holds the result register; stage one keeps taking items
// until it holds one that cannot move on, then in_stall rises.
`default_nettype none

`include "float32_sqrt_interpolated_macros.svh"

module float32_sqrt_interpolated
    import fsi_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [31:0]              operand,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic [EXP_W+MANT_W-1:0]       root
);

    // Stage one: exponent plus registered table read (sign bit is ignored).
    logic                       s1_valid_reg;
    logic [EXP_W-1:0]           expo_reg;

    // Stage two: result register.
    logic                       root_valid_reg;
    logic [EXP_W+MANT_W-1:0]    root_reg;
    logic [EXP_W+MANT_W-1:0]    root_next;

    logic                       s2_load;
    logic                       s1_load;
    logic                       s1_take;
    interp_t                    sel;

    // Result register frees up when empty or being taken this cycle.
    assign s2_load  = !root_valid_reg || !out_stall;
    assign s1_load  = !s1_valid_reg || s2_load;
    assign s1_take  = s1_load && in_valid;
    assign in_stall = !s1_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg   <= 1'b0;
            root_valid_reg <= 1'b0;
        end else begin
            if (s1_load)
                s1_valid_reg <= in_valid;
            if (s2_load)
                root_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_take)
            expo_reg <= operand[EXP_W+MANT_W-1:MANT_W];
        if (s2_load && s1_valid_reg)
            root_reg <= root_next;
    end

    fsi_table u_table (
        .clk  (clk),
        .load (s1_take),
        .frac (operand[MANT_W:0]),
        .sel  (sel)
    );

    fsi_calc u_calc (
        .expo      (expo_reg),
        .sel       (sel),
        .root_next (root_next)
    );

    assign out_valid = root_valid_reg;
    assign root      = root_reg;

    `FSI_ASSERT_NOW(a_stall_needs_item, clk, rst_n, in_stall, s1_valid_reg, "in_stall with empty stage one")
    `FSI_ASSERT_NEXT(a_move_fills_out, clk, rst_n, s2_load && s1_valid_reg, out_valid, "item lost between stages")
    `FSI_ASSERT_NEXT(a_zero_exp, clk, rst_n, s2_load && s1_valid_reg && (expo_reg == '0), root == '0, "zero exponent gave nonzero root")
    `FSI_ASSERT_NEXT(a_exp_range, clk, rst_n, s2_load && s1_valid_reg && (expo_reg != '0), root[EXP_W+MANT_W-1:MANT_W] >= EXP_BIAS_ODD, "result exponent below range")

endmodule

`default_nettype wire

// ===== sim/tb_float32_sqrt_interpolated.sv =====
// Self-checking testbench for float32_sqrt_interpolated: corner and random operands, checked roots.
`timescale 1ns / 1ps

module tb_float32_sqrt_interpolated;

    localparam int ROOT_W = fsi_pkg::EXP_W + fsi_pkg::MANT_W;

    // Constants the block uses, among them the fixed base and slope for when the top nine mantissa bits are all set.
    localparam logic [22:0] ODD_TOP_BASE   = 23'd3474675;
    localparam logic [22:0] EVEN_TOP_BASE  = 23'd8388607;
    localparam logic [31:0] ODD_TOP_SLOPE  = 32'd5792;
    localparam logic [31:0] EVEN_TOP_SLOPE = 32'd8192;
    localparam logic [13:0] CENTER_SLOPE   = 14'd8192;
    localparam logic [8:0]  CENTER_IDX     = 9'd256;
    localparam logic [8:0]  TOP_MANT_ONES  = 9'h1FF;
    localparam logic [15:0] OFFSET_SPAN    = 16'h8000;
    localparam logic [7:0]  ODD_EXP_BIAS   = 8'd64;
    localparam logic [7:0]  EVEN_EXP_BIAS  = 8'd63;

    localparam int N_CORNER     = 25;
    localparam int N_RANDOM     = 1150;
    localparam int N_TOTAL      = N_CORNER + N_RANDOM;
    // Idle mix changes at these item counts: sender-light/receiver-heavy,
    // then swapped, then both sides at full rate.
    localparam int PHASE1_END   = N_CORNER + N_RANDOM / 3;
    localparam int PHASE2_END   = N_CORNER + 2 * N_RANDOM / 3;
    // One long output hold early on so the two stages fill and in_stall rises.
    localparam int HOLD_AT      = 150;
    localparam int HOLD_CYCLES  = 60;
    localparam int DRAIN_CYCLES = 10;
    localparam int STUCK_LIMIT  = 2000;
    localparam int REPORT_MAX   = 10;

    typedef struct {
        logic [31:0]       operand;
        logic [ROOT_W-1:0] root;
    } sqrt_expect_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [31:0]       operand = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [ROOT_W-1:0] root;

    logic [31:0]  pending_operands [$];
    sqrt_expect_t expected_roots [$];
    int           sent_count = 0;
    int           rcvd_count = 0;
    int           mismatch_count = 0;

    float32_sqrt_interpolated dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operand   (operand),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .root      (root)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Root predictor
    // ------------------------------------------------------------------

    // Floor of the square root, two bits at a time.
    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] acc;
        logic [63:0] bitv;
        rem  = v;
        acc  = '0;
        bitv = 64'd1 << 62;
        while (bitv > rem)
            bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= acc + bitv) begin
                rem = rem - (acc + bitv);
                acc = (acc >> 1) + bitv;
            end else begin
                acc = acc >> 1;
            end
            bitv = bitv >> 2;
        end
        return acc;
    endfunction

    // Root table: mantissa of the nearest float32 to sqrt(k/256) for the
    // upper half, sqrt((256+k)/128) for the lower half.
    function automatic logic [22:0] root_mant_at(input logic [8:0] k);
        logic [63:0] n;
        logic [63:0] s;
        logic [63:0] m;
        n = k[8] ? (64'(k) << 38) : ((64'd256 + 64'(k)) << 39);
        s = floor_sqrt(n);
        if (n - s * s > s)
            s = s + 64'd1;
        m = s - (64'd1 << 23);
        return m[22:0];
    endfunction

    // Slope table: rounded reciprocal root, top bits kept.
    function automatic logic [13:0] slope_at(input logic [8:0] k);
        logic [63:0] div;
        logic [63:0] m;
        logic [63:0] t;
        int          e;
        int          sh;
        if (k == CENTER_IDX)
            return CENTER_SLOPE;
        if (k > CENTER_IDX) begin
            e   = 56;
            div = 64'(k);
            sh  = 11;
        end else begin
            e   = 55;
            div = 64'd256 + 64'(k);
            sh  = 10;
        end
        m = floor_sqrt((64'd1 << e) / div);
        t = 64'd2 * m + 64'd1;
        // round to nearest: bump when (m + 1/2)^2 * div is still below 2^e
        if (t * t * div < (64'd1 << (e + 2)))
            m = m + 64'd1;
        m = m >> sh;
        return m[13:0];
    endfunction

    function automatic logic [ROOT_W-1:0] predict_sqrt(input logic [31:0] x);
        logic [7:0]  ex;
        logic [8:0]  idx;
        logic [8:0]  nidx;
        logic [14:0] low;
        logic [15:0] back;
        logic [22:0] base;
        logic [31:0] prod;
        logic [14:0] step;
        logic [22:0] mant;
        logic [7:0]  new_exp;
        ex   = x[30:23];
        idx  = x[23:15];
        nidx = idx + 9'd1;
        low  = x[14:0];
        back = OFFSET_SPAN - {1'b0, low};
        if (x[22:14] == TOP_MANT_ONES) begin
            // no next entry to lean on: fixed base and slope, always backward
            base = x[23] ? ODD_TOP_BASE : EVEN_TOP_BASE;
            prod = 32'(back) * (x[23] ? ODD_TOP_SLOPE : EVEN_TOP_SLOPE);
        end else if (x[14]) begin
            base = root_mant_at(nidx);
            prod = 32'(back) * 32'(slope_at(nidx));
        end else begin
            base = root_mant_at(idx);
            prod = 32'(low) * 32'(slope_at(idx));
        end
        step = prod[28:14];
        // carry or borrow out of the mantissa is dropped
        mant    = x[14] ? base - 23'(step) : base + 23'(step);
        new_exp = (ex >> 1) + (x[23] ? ODD_EXP_BIAS : EVEN_EXP_BIAS);
        return (ex == 8'd0) ? '0 : {new_exp, mant};
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Random operand, biased toward the interesting regions.
    function automatic logic [31:0] random_operand();
        logic [31:0] x;
        int          pick;
        x    = $urandom;
        pick = $urandom_range(99);
        if (pick < 60) begin
            // fully random word
        end else if (pick < 70) begin
            x[30:23] = 8'd0;                    // zero / subnormal
        end else if (pick < 80) begin
            x[22:14] = TOP_MANT_ONES;           // fixed-constant path
        end else if (pick < 88) begin
            x[30:23] = 8'hFF;                   // inf / NaN exponent
        end else if (pick < 94) begin
            x[22:15] = x[0] ? 8'hFF : 8'h00;    // around the table midpoint
        end else begin
            case ($urandom_range(2))
                0:       x[14:0] = 15'h0000;
                1:       x[14:0] = 15'h7FFF;
                default: x[14:0] = 15'h4000;
            endcase
        end
        return x;
    endfunction

    function automatic int send_idle_pct(input int n);
        if (n < PHASE1_END)
            return 19;
        if (n < PHASE2_END)
            return 56;
        return 0;
    endfunction

    function automatic int recv_idle_pct(input int n);
        if (n < PHASE1_END)
            return 56;
        if (n < PHASE2_END)
            return 19;
        return 0;
    endfunction

    task automatic log_mismatch(input string what, input logic [31:0] op,
                                input logic [ROOT_W-1:0] want,
                                input logic [ROOT_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("%s: operand %h expected %h got %h", what, op, want, got);
    endtask

    logic [31:0] corner_operands [N_CORNER] = '{
        32'h0000_0000,  // zero
        32'h8000_0000,  // negative zero
        32'h0000_0001,  // smallest subnormal
        32'h807F_FFFF,  // negative largest subnormal
        32'h0080_0000,  // smallest normal, odd exponent
        32'h3F80_0000,  // 1.0: midpoint entry
        32'h3F80_3FFF,  // forward from midpoint, largest offset
        32'h4000_0000,  // 2.0: first entry, even exponent
        32'h4080_0000,  // 4.0
        32'h3F80_4000,  // backward, half-span offset
        32'h3FFF_8000,  // forward from last entry
        32'h3FFF_BFFF,  // forward from last entry, largest offset
        32'h3FFF_C000,  // top mantissa all ones, odd exponent
        32'h3FFF_FFFF,  // same, smallest backward offset
        32'h407F_C000,  // top mantissa all ones, even exponent
        32'h407F_FFFF,
        32'h407F_BFFF,  // forward from entry 255, largest offset
        32'h7F7F_FFFF,  // largest finite
        32'h7F80_0000,  // infinity
        32'h7FC0_0001,  // NaN
        32'hFFFF_FFFF,  // all ones
        32'hC080_0000,  // negative operand
        32'h4000_7FFF,  // backward into entry 1, offset of one
        32'h5555_5555,
        32'h2AAA_AAAA
    };

    initial begin
        foreach (corner_operands[i])
            pending_operands.push_back(corner_operands[i]);
        repeat (N_RANDOM)
            pending_operands.push_back(random_operand());

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Everything offered, accepted and checked, then let the pipe drain
        // so a stray result would still be caught.
        while (!(sent_count == N_TOTAL && expected_roots.size() == 0))
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver: holds each item until taken; random gaps only between items,
    // so valid never reacts to in_stall.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin : drive_operands
        sqrt_expect_t entry;
        logic         taken;
        logic         free;
        if (!rst_n) begin
            in_valid <= 1'b0;
            operand  <= '0;
        end else begin
            taken = in_valid && !in_stall;
            if (taken) begin
                entry.operand = operand;
                entry.root    = predict_sqrt(operand);
                expected_roots.push_back(entry);
                sent_count++;
            end
            free = !in_valid || taken;
            if (free && pending_operands.size() > 0 &&
                $urandom_range(99) >= send_idle_pct(sent_count)) begin
                in_valid <= 1'b1;
                operand  <= pending_operands.pop_front();
            end else if (free) begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each taken root against the oldest prediction and
    // drives out_stall, including the one long hold-off.
    // ------------------------------------------------------------------
    int   hold_left = 0;
    logic hold_done = 1'b0;

    always @(posedge clk or negedge rst_n) begin : check_roots
        sqrt_expect_t entry;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_roots.size() == 0) begin
                    log_mismatch("unexpected root", 32'hx, 'x, root);
                end else begin
                    entry = expected_roots.pop_front();
                    if (root !== entry.root)
                        log_mismatch("root mismatch", entry.operand, entry.root, root);
                end
                rcvd_count++;
            end
            if (!hold_done && rcvd_count >= HOLD_AT) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(99) < recv_idle_pct(rcvd_count));
            end
        end
    end

    // Watchdog: too many cycles with no item moving on either side.
    int stuck_cycles = 0;

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("timeout: no item moved for %0d cycles", STUCK_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

endmodule
